// ----- hw/rtl/sgc_pkg.sv -----
// Shared types and constants for the segment geometry pipeline.
// No dependencies.
package sgc_pkg;

  localparam int COORD_W = 32;
  localparam int LEN_W   = 33;
  localparam int SUM_W   = 65;
  localparam int SQC_W   = 67;
  localparam int NUM_W   = 63;
  localparam int QUO_W   = 31;
  localparam int TAN_W   = 32;
  localparam int CX_W    = 50;
  localparam int Z_W     = 34;
  localparam int SQ_N    = 33;
  localparam int DIV_N   = 31;

  localparam logic [30:0] INV_2SQRT2_Q32 = 31'd1518500250;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [Z_W-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic [QUO_W-1:0] ONE_Q30 = 31'd1073741824;

  localparam logic signed [Z_W-1:0] ATAN_Q30 [32] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
    34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288, 34'sd262144,
    34'sd131072, 34'sd65536, 34'sd32768, 34'sd16384, 34'sd8192, 34'sd4096,
    34'sd2048, 34'sd1024, 34'sd512, 34'sd256, 34'sd128, 34'sd64, 34'sd32,
    34'sd16, 34'sd8, 34'sd4, 34'sd2, 34'sd1, 34'sd0};

  typedef struct packed {
    logic [15:0]               element_index;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      interp_order;
  } elem_t;

  typedef struct packed {
    logic [15:0]               tag_index;
    logic [LEN_W-1:0]          seg_length;
    logic signed [TAN_W-1:0]   tangent_x;
    logic signed [TAN_W-1:0]   tangent_y;
    logic signed [31:0]        angle;
    logic signed [COORD_W-1:0] mid_x;
    logic signed [COORD_W-1:0] mid_y;
    logic signed [COORD_W-1:0] colloc0_x;
    logic signed [COORD_W-1:0] colloc0_y;
    logic signed [COORD_W-1:0] colloc1_x;
    logic signed [COORD_W-1:0] colloc1_y;
  } geo_t;

  typedef struct packed {
    logic [15:0]               tag;
    logic signed [COORD_W-1:0] mid_x;
    logic signed [COORD_W-1:0] mid_y;
    logic signed [COORD_W-1:0] c0_x;
    logic signed [COORD_W-1:0] c0_y;
    logic signed [COORD_W-1:0] c1_x;
    logic signed [COORD_W-1:0] c1_y;
    logic [COORD_W-1:0]        ux;
    logic [COORD_W-1:0]        uy;
    logic                      neg_x;
    logic                      neg_y;
  } side_t;

endpackage

// ----- hw/rtl/sgc_sqrt_cell.sv -----
// One bit of the restoring square root: tries root + 2^BIT_POS.
// Depends on sgc_pkg.
module sgc_sqrt_cell #(
  parameter int BIT_POS = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [sgc_pkg::SUM_W-1:0]  rem_in,
  input  logic [sgc_pkg::LEN_W-1:0]  root_in,
  output logic [sgc_pkg::SUM_W-1:0]  rem_out,
  output logic [sgc_pkg::LEN_W-1:0]  root_out
);
  import sgc_pkg::*;

  logic [SQC_W-1:0] trial;
  logic [SQC_W-1:0] rem_ext;
  logic             take;

  assign trial   = (SQC_W'(root_in) << (BIT_POS + 1)) + (SQC_W'(1) << (2 * BIT_POS));
  assign rem_ext = SQC_W'(rem_in);
  assign take    = rem_ext >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? SUM_W'(rem_ext - trial) : rem_in;
      root_out <= take ? (root_in | (LEN_W'(1) << BIT_POS)) : root_in;
    end
  end

endmodule

// ----- hw/rtl/sgc_div_cell.sv -----
// One quotient bit of the restoring divider: subtracts divisor << BIT_POS.
// Depends on sgc_pkg.
module sgc_div_cell #(
  parameter int BIT_POS = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [sgc_pkg::NUM_W-1:0]  rem_in,
  input  logic [sgc_pkg::QUO_W-1:0]  quo_in,
  input  logic [sgc_pkg::LEN_W-1:0]  len_in,
  output logic [sgc_pkg::NUM_W-1:0]  rem_out,
  output logic [sgc_pkg::QUO_W-1:0]  quo_out,
  output logic [sgc_pkg::LEN_W-1:0]  len_out
);
  import sgc_pkg::*;

  logic [NUM_W:0] dsh;
  logic           take;

  assign dsh  = (NUM_W+1)'(len_in) << BIT_POS;
  assign take = {1'b0, rem_in} >= dsh;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? NUM_W'({1'b0, rem_in} - dsh) : rem_in;
      quo_out <= take ? (quo_in | (QUO_W'(1) << BIT_POS)) : quo_in;
      len_out <= len_in;
    end
  end

endmodule

// ----- hw/rtl/sgc_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation, driving y toward zero.
// Depends on sgc_pkg.
module sgc_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [sgc_pkg::CX_W-1:0]   x_in,
  input  logic signed [sgc_pkg::CX_W-1:0]   y_in,
  input  logic signed [sgc_pkg::Z_W-1:0]    z_in,
  output logic signed [sgc_pkg::CX_W-1:0]   x_out,
  output logic signed [sgc_pkg::CX_W-1:0]   y_out,
  output logic signed [sgc_pkg::Z_W-1:0]    z_out
);
  import sgc_pkg::*;

  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;

  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[CX_W-1]) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN_Q30[STAGE];
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN_Q30[STAGE];
      end
    end
  end

endmodule

// ----- hw/rtl/segment_geometry_collocation.sv -----
// Top level: straight-element length, tangent, angle and collocation points.
// Depends on sgc_pkg, sgc_sqrt_cell, sgc_div_cell, sgc_cordic_cell.
//
//   channel | signals                        | dir | word
//   elem    | elem_valid, elem_ready, elem   | in  | sgc_pkg::elem_t
//   geo     | geo_valid, geo_ready, geo      | out | sgc_pkg::geo_t
//
// One word per cycle while the output buffer has room; the pipeline runs through
// 33 square-root cells, two chains of 31 divider cells and CORDIC_STAGES rotation cells.
// The whole chain advances while the two-word output buffer has room.
// rst clears all valid bits and the buffer.
module segment_geometry_collocation #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           elem_valid,
  output logic           elem_ready,
  input  sgc_pkg::elem_t elem,
  output logic           geo_valid,
  input  logic           geo_ready,
  output sgc_pkg::geo_t  geo
);
  import sgc_pkg::*;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W+1:0] v);
    logic signed [COORD_W+1:0] hi;
    logic signed [COORD_W+1:0] lo;
    hi = (COORD_W+2)'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  logic       en;
  logic [1:0] cnt;
  geo_t       slot0;
  geo_t       slot1;

  assign en         = cnt != 2'd2;
  assign elem_ready = en;

  // stage 0: differences, magnitudes, midpoint
  logic signed [COORD_W:0]   dx_c;
  logic signed [COORD_W:0]   dy_c;
  logic signed [COORD_W:0]   smx_c;
  logic signed [COORD_W:0]   smy_c;
  logic                      v0;
  logic [15:0]               tag0;
  logic [COORD_W-1:0]        ux0;
  logic [COORD_W-1:0]        uy0;
  logic                      nx0;
  logic                      ny0;
  logic signed [COORD_W-1:0] mx0;
  logic signed [COORD_W-1:0] my0;
  logic                      ord0;

  assign dx_c  = $signed({elem.end_x[COORD_W-1], elem.end_x})
               - $signed({elem.start_x[COORD_W-1], elem.start_x});
  assign dy_c  = $signed({elem.end_y[COORD_W-1], elem.end_y})
               - $signed({elem.start_y[COORD_W-1], elem.start_y});
  assign smx_c = $signed({elem.end_x[COORD_W-1], elem.end_x})
               + $signed({elem.start_x[COORD_W-1], elem.start_x});
  assign smy_c = $signed({elem.end_y[COORD_W-1], elem.end_y})
               + $signed({elem.start_y[COORD_W-1], elem.start_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= elem_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag0 <= elem.element_index;
      ux0  <= dx_c[COORD_W] ? COORD_W'(-dx_c) : dx_c[COORD_W-1:0];
      uy0  <= dy_c[COORD_W] ? COORD_W'(-dy_c) : dy_c[COORD_W-1:0];
      nx0  <= dx_c[COORD_W];
      ny0  <= dy_c[COORD_W];
      mx0  <= smx_c[COORD_W:1];
      my0  <= smy_c[COORD_W:1];
      ord0 <= elem.interp_order;
    end
  end

  // stage 1: squares and offset products
  logic                      v1;
  logic [2*COORD_W-1:0]      sqx1;
  logic [2*COORD_W-1:0]      sqy1;
  logic [NUM_W-1:0]          px1;
  logic [NUM_W-1:0]          py1;
  logic [15:0]               tag1;
  logic [COORD_W-1:0]        ux1;
  logic [COORD_W-1:0]        uy1;
  logic                      nx1;
  logic                      ny1;
  logic signed [COORD_W-1:0] mx1;
  logic signed [COORD_W-1:0] my1;
  logic                      ord1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx1 <= ux0 * ux0;
      sqy1 <= uy0 * uy0;
      px1  <= ux0 * INV_2SQRT2_Q32;
      py1  <= uy0 * INV_2SQRT2_Q32;
      tag1 <= tag0;
      ux1  <= ux0;
      uy1  <= uy0;
      nx1  <= nx0;
      ny1  <= ny0;
      mx1  <= mx0;
      my1  <= my0;
      ord1 <= ord0;
    end
  end

  // stage 2: sum of squares and collocation points
  logic [COORD_W-1:0]        ox_c;
  logic [COORD_W-1:0]        oy_c;
  logic signed [COORD_W+1:0] offx_c;
  logic signed [COORD_W+1:0] offy_c;
  logic signed [COORD_W+1:0] mxe_c;
  logic signed [COORD_W+1:0] mye_c;
  logic                      v2;
  logic [SUM_W-1:0]          sum2;
  side_t                     side2;

  assign ox_c   = COORD_W'((64'(px1) + 64'h8000_0000) >> 32);
  assign oy_c   = COORD_W'((64'(py1) + 64'h8000_0000) >> 32);
  assign offx_c = nx1 ? -$signed({2'b00, ox_c}) : $signed({2'b00, ox_c});
  assign offy_c = ny1 ? -$signed({2'b00, oy_c}) : $signed({2'b00, oy_c});
  assign mxe_c  = (COORD_W+2)'(mx1);
  assign mye_c  = (COORD_W+2)'(my1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum2        <= {1'b0, sqx1} + {1'b0, sqy1};
      side2.tag   <= tag1;
      side2.mid_x <= mx1;
      side2.mid_y <= my1;
      side2.ux    <= ux1;
      side2.uy    <= uy1;
      side2.neg_x <= nx1;
      side2.neg_y <= ny1;
      if (ord1) begin
        side2.c0_x <= sat_coord(mxe_c - offx_c);
        side2.c0_y <= sat_coord(mye_c - offy_c);
        side2.c1_x <= sat_coord(mxe_c + offx_c);
        side2.c1_y <= sat_coord(mye_c + offy_c);
      end else begin
        side2.c0_x <= mx1;
        side2.c0_y <= my1;
        side2.c1_x <= '0;
        side2.c1_y <= '0;
      end
    end
  end

  // square-root chain
  logic [SUM_W-1:0] sq_rem  [SQ_N+1];
  logic [LEN_W-1:0] sq_root [SQ_N+1];
  side_t            sq_side [SQ_N+1];
  logic             sq_v    [SQ_N+1];

  assign sq_rem[0]  = sum2;
  assign sq_root[0] = '0;
  assign sq_side[0] = side2;
  assign sq_v[0]    = v2;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    sgc_sqrt_cell #(.BIT_POS(SQ_N - 1 - k)) u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // dividend setup
  logic             vp;
  logic [NUM_W-1:0] nump_x;
  logic [NUM_W-1:0] nump_y;
  logic [LEN_W-1:0] lenp;
  side_t            sidep;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= sq_v[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nump_x <= (NUM_W'(sq_side[SQ_N].ux) << 30) + NUM_W'(sq_root[SQ_N] >> 1);
      nump_y <= (NUM_W'(sq_side[SQ_N].uy) << 30) + NUM_W'(sq_root[SQ_N] >> 1);
      lenp   <= sq_root[SQ_N];
      sidep  <= sq_side[SQ_N];
    end
  end

  // divider chains
  logic [NUM_W-1:0] dx_rem [DIV_N+1];
  logic [QUO_W-1:0] dx_quo [DIV_N+1];
  logic [LEN_W-1:0] dx_len [DIV_N+1];
  logic [NUM_W-1:0] dy_rem [DIV_N+1];
  logic [QUO_W-1:0] dy_quo [DIV_N+1];
  logic [LEN_W-1:0] dy_len [DIV_N+1];
  side_t            dv_side [DIV_N+1];
  logic             dv_v    [DIV_N+1];

  assign dx_rem[0]  = nump_x;
  assign dx_quo[0]  = '0;
  assign dx_len[0]  = lenp;
  assign dy_rem[0]  = nump_y;
  assign dy_quo[0]  = '0;
  assign dy_len[0]  = lenp;
  assign dv_side[0] = sidep;
  assign dv_v[0]    = vp;

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    sgc_div_cell #(.BIT_POS(DIV_N - 1 - j)) u_cell_x (
      .clk     (clk),
      .en      (en),
      .rem_in  (dx_rem[j]),
      .quo_in  (dx_quo[j]),
      .len_in  (dx_len[j]),
      .rem_out (dx_rem[j+1]),
      .quo_out (dx_quo[j+1]),
      .len_out (dx_len[j+1])
    );
    sgc_div_cell #(.BIT_POS(DIV_N - 1 - j)) u_cell_y (
      .clk     (clk),
      .en      (en),
      .rem_in  (dy_rem[j]),
      .quo_in  (dy_quo[j]),
      .len_in  (dy_len[j]),
      .rem_out (dy_rem[j+1]),
      .quo_out (dy_quo[j+1]),
      .len_out (dy_len[j+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_side[j+1] <= dv_side[j];
      end
    end
  end

  // tangent
  logic [QUO_W-1:0] qx_c;
  logic [QUO_W-1:0] qy_c;
  logic             zero_c;
  logic             vt;
  logic             zero_t;
  geo_t             res_t;

  assign qx_c   = (dx_quo[DIV_N] > ONE_Q30) ? ONE_Q30 : dx_quo[DIV_N];
  assign qy_c   = (dy_quo[DIV_N] > ONE_Q30) ? ONE_Q30 : dy_quo[DIV_N];
  assign zero_c = dx_len[DIV_N] == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else if (en) begin
      vt <= dv_v[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_t           <= zero_c;
      res_t.tag_index  <= dv_side[DIV_N].tag;
      res_t.seg_length <= dx_len[DIV_N];
      res_t.angle      <= '0;
      res_t.mid_x      <= dv_side[DIV_N].mid_x;
      res_t.mid_y      <= dv_side[DIV_N].mid_y;
      res_t.colloc0_x  <= dv_side[DIV_N].c0_x;
      res_t.colloc0_y  <= dv_side[DIV_N].c0_y;
      res_t.colloc1_x  <= dv_side[DIV_N].c1_x;
      res_t.colloc1_y  <= dv_side[DIV_N].c1_y;
      if (zero_c) begin
        res_t.tangent_x <= '0;
        res_t.tangent_y <= '0;
      end else begin
        res_t.tangent_x <= dv_side[DIV_N].neg_x ? -TAN_W'(qx_c) : TAN_W'(qx_c);
        res_t.tangent_y <= dv_side[DIV_N].neg_y ? -TAN_W'(qy_c) : TAN_W'(qy_c);
      end
    end
  end

  // quadrant fold ahead of CORDIC
  logic signed [CX_W-1:0] tx_w;
  logic signed [CX_W-1:0] ty_w;
  logic                   vq;
  logic                   zero_q;
  geo_t                   res_q;
  logic signed [CX_W-1:0] xq;
  logic signed [CX_W-1:0] yq;
  logic signed [Z_W-1:0]  zq;

  assign tx_w = {{2{res_t.tangent_x[TAN_W-1]}}, res_t.tangent_x, 16'h0000};
  assign ty_w = {{2{res_t.tangent_y[TAN_W-1]}}, res_t.tangent_y, 16'h0000};

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else if (en) begin
      vq <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_q <= zero_t;
      res_q  <= res_t;
      if (!tx_w[CX_W-1]) begin
        xq <= tx_w;
        yq <= ty_w;
        zq <= '0;
      end else if (!ty_w[CX_W-1]) begin
        xq <= ty_w;
        yq <= -tx_w;
        zq <= HALF_PI_Q30;
      end else begin
        xq <= -ty_w;
        yq <= tx_w;
        zq <= -HALF_PI_Q30;
      end
    end
  end

  // CORDIC chain
  logic signed [CX_W-1:0] cx [CORDIC_STAGES+1];
  logic signed [CX_W-1:0] cy [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  cz [CORDIC_STAGES+1];
  geo_t                   cd_res  [CORDIC_STAGES+1];
  logic                   cd_zero [CORDIC_STAGES+1];
  logic                   cd_v    [CORDIC_STAGES+1];

  assign cx[0]      = xq;
  assign cy[0]      = yq;
  assign cz[0]      = zq;
  assign cd_res[0]  = res_q;
  assign cd_zero[0] = zero_q;
  assign cd_v[0]    = vq;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    sgc_cordic_cell #(.STAGE(i)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (cx[i]),
      .y_in  (cy[i]),
      .z_in  (cz[i]),
      .x_out (cx[i+1]),
      .y_out (cy[i+1]),
      .z_out (cz[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        cd_v[i+1] <= 1'b0;
      end else if (en) begin
        cd_v[i+1] <= cd_v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cd_res[i+1]  <= cd_res[i];
        cd_zero[i+1] <= cd_zero[i];
      end
    end
  end

  // final rounding to Q3.29 and output buffer
  logic signed [Z_W-1:0] zr_c;
  logic signed [Z_W-1:0] zc_c;
  geo_t                  fin_c;
  logic                  push;
  logic                  pop;

  assign zr_c = (cz[CORDIC_STAGES] + Z_W'(1)) >>> 1;
  assign zc_c = (zr_c > PI_Q29) ? PI_Q29 : ((zr_c < -PI_Q29) ? -PI_Q29 : zr_c);

  always_comb begin
    fin_c       = cd_res[CORDIC_STAGES];
    fin_c.angle = cd_zero[CORDIC_STAGES] ? 32'sd0 : zc_c[31:0];
  end

  assign push      = en && cd_v[CORDIC_STAGES];
  assign pop       = geo_valid && geo_ready;
  assign geo_valid = cnt != 2'd0;
  assign geo       = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) slot0 <= fin_c;
        else slot1 <= fin_c;
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          slot0 <= fin_c;
        end else begin
          slot0 <= slot1;
          slot1 <= fin_c;
        end
      end
      default: begin
        slot0 <= slot0;
      end
    endcase
  end

endmodule
